FILE: hw/rtl/nmeack_pkg.sv
// Shared types and constants for the NMEA checksum and sentence-type classifier.
package nmeack_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned ID_BYTES = 5;
	localparam int unsigned ID_W = BYTE_W * ID_BYTES;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [BYTE_W-1:0] STAR_CHAR = 8'h2A;

	localparam logic [ID_W-1:0] FIRST_PATTERN_RST = 40'h47_50_47_47_41;
	localparam logic [ID_W-1:0] SECOND_PATTERN_RST = 40'h47_50_52_4D_43;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_FIRST = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_SECOND = 2'd1;

	typedef enum logic [1:0] {
		KIND_CSUM_ERROR = 2'd0,
		KIND_FIRST = 2'd1,
		KIND_SECOND = 2'd2,
		KIND_UNKNOWN = 2'd3
	} sentence_kind_t;

	typedef struct packed {
		logic [BYTE_W-1:0] char_in;
		logic end_of_sentence;
	} char_item_t;

	typedef struct packed {
		sentence_kind_t sentence_kind;
		logic [BYTE_W-1:0] computed_sum;
		logic [BYTE_W-1:0] received_sum;
	} result_item_t;

endpackage

FILE: hw/rtl/nmea_checksum_type_classifier.sv
// Top level of the NMEA sentence checksum checker and sentence-type classifier.
//
// Usage: sentence bytes arrive on the char channel (char_valid/char_ready, payload
// char_item), one byte per request, with end_of_sentence set on the final byte.
// Every byte after the first is XORed up to the first '*'; the hex digits after the
// '*' form the received checksum. A five-byte sliding window looks for the two
// sentence IDs held in the configuration registers. After the final byte one
// request leaves on the result channel (result_valid/result_ready, payload result)
// with the sentence kind and both checksums. Other bytes produce no result.
// The cfg channel writes register 0 (first ID) or 1 (second ID); other indexes
// are ignored. It is always ready and is meant to be used only while idle.
// Path: a byte is held in the input register, where the scanner folds it into the
// sentence state; when the final byte leaves that register, the result is loaded
// into the result register, from which it is shown on the result channel.
// Throughput: one byte per cycle, set by the single input register feeding the
// scanner. The input register keeps taking bytes while a result waits; only a
// final byte stalls, and only while the previous result is still not taken.
// Reset: IDs return to GPGGA and GPRMC, the sentence state clears, and both
// channels come up empty.
module nmea_checksum_type_classifier (
	input logic clk,
	input logic arst_n,
	input logic char_valid,
	output logic char_ready,
	input nmeack_pkg::char_item_t char_item,
	output logic result_valid,
	input logic result_ready,
	output nmeack_pkg::result_item_t result,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [nmeack_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [nmeack_pkg::ID_W-1:0] cfg_data
);

	logic [nmeack_pkg::ID_W-1:0] first_pattern_q;
	logic [nmeack_pkg::ID_W-1:0] second_pattern_q;
	logic valid_s1;
	nmeack_pkg::char_item_t item_s1;
	nmeack_pkg::result_item_t result_d;
	nmeack_pkg::result_item_t result_q;
	logic result_valid_q;
	logic adv;
	logic load;

	// Configuration writes take effect at once.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_pattern_q <= nmeack_pkg::FIRST_PATTERN_RST;
			second_pattern_q <= nmeack_pkg::SECOND_PATTERN_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				nmeack_pkg::CFG_IDX_FIRST: first_pattern_q <= cfg_data;
				nmeack_pkg::CFG_IDX_SECOND: second_pattern_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A held byte moves on unless it is a final byte and the result register is
	// still occupied by a result that the receiver has not taken.
	assign adv = valid_s1 && (!item_s1.end_of_sentence || !result_valid_q || result_ready);
	assign load = adv && item_s1.end_of_sentence;

	nmeack_in_stage u_in_stage (
		.clk(clk),
		.arst_n(arst_n),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_item(char_item),
		.take(adv),
		.valid_s1(valid_s1),
		.item_s1(item_s1)
	);

	nmeack_scan u_scan (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv),
		.item_s1(item_s1),
		.first_pattern(first_pattern_q),
		.second_pattern(second_pattern_q),
		.result_d(result_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	// A pending result must never be overwritten by the next sentence.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_ready) |-> !load)
		else $error("result overwritten while stalled");

	// A finished sentence always shows up as a result in the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> result_valid_q)
		else $error("loaded result not presented");

	// The input side only stalls when the held byte cannot move on.
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!char_ready |-> (valid_s1 && item_s1.end_of_sentence && result_valid_q))
		else $error("input stalled without cause");

	// A held byte that does not advance stays in place.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(item_s1)))
		else $error("held byte lost or changed");

endmodule

FILE: hw/rtl/nmeack_in_stage.sv
// Input register stage that holds one byte request until the scanner consumes it.
module nmeack_in_stage (
	input logic clk,
	input logic arst_n,
	input logic char_valid,
	output logic char_ready,
	input nmeack_pkg::char_item_t char_item,
	input logic take,
	output logic valid_s1,
	output nmeack_pkg::char_item_t item_s1
);

	logic accept;

	// The stage refills in the same cycle that its byte is consumed.
	assign char_ready = !valid_s1 || take;
	assign accept = char_valid && char_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= char_item;
		end
	end

endmodule

FILE: hw/rtl/nmeack_scan.sv
// Per-sentence scanner: running XOR, hex reader, ID window and classification.
module nmeack_scan (
	input logic clk,
	input logic arst_n,
	input logic step,
	input nmeack_pkg::char_item_t item_s1,
	input logic [nmeack_pkg::ID_W-1:0] first_pattern,
	input logic [nmeack_pkg::ID_W-1:0] second_pattern,
	output nmeack_pkg::result_item_t result_d
);

	localparam int unsigned WIN_W = nmeack_pkg::ID_W - nmeack_pkg::BYTE_W;

	logic first_byte_pending_q;
	logic star_seen_q;
	logic hex_stopped_q;
	logic [nmeack_pkg::BYTE_W-1:0] xor_acc_q;
	logic [nmeack_pkg::BYTE_W-1:0] hex_acc_q;
	logic [WIN_W-1:0] recent_q;
	logic first_matched_q;
	logic second_matched_q;

	logic star_seen_d;
	logic hex_stopped_d;
	logic [nmeack_pkg::BYTE_W-1:0] xor_acc_d;
	logic [nmeack_pkg::BYTE_W-1:0] hex_acc_d;
	logic [nmeack_pkg::ID_W-1:0] window;
	logic first_matched_d;
	logic second_matched_d;
	logic [4:0] digit;
	logic [nmeack_pkg::BYTE_W-1:0] c;

	// Returns {is_digit, value}.
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end
		return r;
	endfunction

	// A pattern holding a zero byte is never allowed to match.
	function automatic logic usable(input logic [nmeack_pkg::ID_W-1:0] pat);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < nmeack_pkg::ID_BYTES; i++) begin
			if (pat[i*nmeack_pkg::BYTE_W +: nmeack_pkg::BYTE_W] == '0) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

	assign c = item_s1.char_in;
	assign digit = hex_digit(c);
	assign window = {recent_q, c};

	always_comb begin
		star_seen_d = star_seen_q;
		hex_stopped_d = hex_stopped_q;
		xor_acc_d = xor_acc_q;
		hex_acc_d = hex_acc_q;
		if (star_seen_q) begin
			if (!hex_stopped_q) begin
				if (digit[4]) begin
					hex_acc_d = {hex_acc_q[3:0], digit[3:0]};
				end else begin
					hex_stopped_d = 1'b1;
				end
			end
		end else if (c == nmeack_pkg::STAR_CHAR) begin
			star_seen_d = 1'b1;
		end else if (!first_byte_pending_q) begin
			xor_acc_d = xor_acc_q ^ c;
		end
		first_matched_d = first_matched_q || (window == first_pattern && usable(first_pattern));
		second_matched_d = second_matched_q
			|| (window == second_pattern && usable(second_pattern));
	end

	always_comb begin
		result_d.computed_sum = xor_acc_d;
		result_d.received_sum = hex_acc_d;
		if (!star_seen_d || xor_acc_d != hex_acc_d) begin
			result_d.sentence_kind = nmeack_pkg::KIND_CSUM_ERROR;
		end else if (first_matched_d) begin
			result_d.sentence_kind = nmeack_pkg::KIND_FIRST;
		end else if (second_matched_d) begin
			result_d.sentence_kind = nmeack_pkg::KIND_SECOND;
		end else begin
			result_d.sentence_kind = nmeack_pkg::KIND_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_byte_pending_q <= 1'b1;
			star_seen_q <= 1'b0;
			hex_stopped_q <= 1'b0;
			xor_acc_q <= '0;
			hex_acc_q <= '0;
			recent_q <= '0;
			first_matched_q <= 1'b0;
			second_matched_q <= 1'b0;
		end else if (step) begin
			if (item_s1.end_of_sentence) begin
				first_byte_pending_q <= 1'b1;
				star_seen_q <= 1'b0;
				hex_stopped_q <= 1'b0;
				xor_acc_q <= '0;
				hex_acc_q <= '0;
				recent_q <= '0;
				first_matched_q <= 1'b0;
				second_matched_q <= 1'b0;
			end else begin
				first_byte_pending_q <= 1'b0;
				star_seen_q <= star_seen_d;
				hex_stopped_q <= hex_stopped_d;
				xor_acc_q <= xor_acc_d;
				hex_acc_q <= hex_acc_d;
				recent_q <= window[WIN_W-1:0];
				first_matched_q <= first_matched_d;
				second_matched_q <= second_matched_d;
			end
		end
	end

endmodule
